@@ sv/lcrs_pkg.sv @@
// Shared constants, types and helpers of the lane center row scanner.
package lcrs_pkg;

    localparam int BAND_ROWS     = 44;
    localparam int IMAGE_WIDTH   = 320;
    localparam int WORD_BITS     = 32;
    localparam int WB_LOG        = $clog2(WORD_BITS);
    localparam int WORDS_PER_ROW = (IMAGE_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_DEPTH   = BAND_ROWS * WORDS_PER_ROW;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int LAST_BITS     = IMAGE_WIDTH - (WORDS_PER_ROW - 1) * WORD_BITS;

    localparam int COL_W   = 9;
    localparam int ROW_W   = 6;
    localparam int WIDX_W  = 4;
    localparam int PIX_W   = 32;
    localparam int COLX_W  = COL_W + 1;
    localparam int WCNT_W  = COLX_W - WB_LOG;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

    localparam logic [COL_W-1:0] START_COL_RST   = COL_W'(160);
    localparam logic [COL_W-1:0] LEFT_LIMIT_RST  = COL_W'(1);
    localparam logic [COL_W-1:0] RIGHT_LIMIT_RST = COL_W'(318);

    localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_L_START,
        ST_L_PRIME,
        ST_L_EVAL,
        ST_R_START,
        ST_R_PRIME,
        ST_R_EVAL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              dir_right;
        logic [WCNT_W-1:0] word;
        logic [1:0]        nb;
        logic [COLX_W-1:0] lo;
        logic [COLX_W-1:0] hi;
    } t_search_req;

    typedef struct packed {
        logic              hit;
        logic [WB_LOG-1:0] pos;
    } t_search_res;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                     input logic [WCNT_W-1:0] word);
        int a;
        a = int'(row) * WORDS_PER_ROW + int'(word);
        return ADDR_W'(a);
    endfunction

endpackage

@@ sv/lcrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 440
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

@@ sv/lcrs_word_search.sv @@
// Shared word search unit: pair detect, column window mask and priority pick.
module lcrs_word_search
    import lcrs_pkg::*;
(
    input  t_search_req          i_req,
    input  logic [WORD_BITS-1:0] i_data,
    output t_search_res          o_res
);
    logic [WORD_BITS-1:0] pair;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] cand;
    logic [WCNT_W-1:0]    lo_w;
    logic [WCNT_W-1:0]    hi_w;
    logic [WB_LOG-1:0]    lo_b;
    logic [WB_LOG-1:0]    hi_b;

    assign lo_w = i_req.lo[COLX_W-1:WB_LOG];
    assign hi_w = i_req.hi[COLX_W-1:WB_LOG];
    assign lo_b = i_req.lo[WB_LOG-1:0];
    assign hi_b = i_req.hi[WB_LOG-1:0];

    always_comb begin
        if (i_req.dir_right) begin
            pair = i_data & {i_data[WORD_BITS-3:0], i_req.nb};
        end else begin
            pair = i_data & {i_req.nb[0], i_data[WORD_BITS-1:1]};
        end

        if (i_req.word > lo_w) begin
            lo_mask = '1;
        end else if (i_req.word == lo_w) begin
            lo_mask = {WORD_BITS{1'b1}} << lo_b;
        end else begin
            lo_mask = '0;
        end

        if (i_req.word < hi_w) begin
            hi_mask = '1;
        end else if (i_req.word == hi_w) begin
            hi_mask = {WORD_BITS{1'b1}} >> (~hi_b);
        end else begin
            hi_mask = '0;
        end

        cand = pair & lo_mask & hi_mask;
    end

    always_comb begin
        o_res.hit = |cand;
        o_res.pos = '0;
        if (i_req.dir_right) begin
            for (int j = WORD_BITS - 1; j >= 0; j--) begin
                if (cand[j]) begin
                    o_res.pos = WB_LOG'(j);
                end
            end
        end else begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (cand[j]) begin
                    o_res.pos = WB_LOG'(j);
                end
            end
        end
    end
endmodule

@@ sv/lane_center_row_scanner.sv @@
// Top level: word store, row scan sequencer, configuration and result register.
// A word without the frame end mark is stored and gives no result.
// A frame end starts the scan, which gives one result per band row.
// Throughput: one word per cycle while loading; the input is held off during the scan.
// Reset is synchronous and active low; the pixel store is not cleared by it.
module lane_center_row_scanner
    import lcrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // row_index[5:0], word_index[9:6], pixel_bits[41:10], zero fill above.
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // out_row[5:0], left_col[14:6], right_col[23:15], mid_col[32:24], zero fill above.
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // left_hit[0], right_hit[1].
    output logic [OUT_TUSER_W-1:0] o_m_tuser,
    output logic                   o_m_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COL_W-1:0]       i_cfg_data
);
    t_state               r_state;
    t_state               n_state;
    logic [COL_W-1:0]     r_start_col;
    logic [COL_W-1:0]     r_left_limit;
    logic [COL_W-1:0]     r_right_limit;
    logic [COL_W-1:0]     r_begin;
    logic [ROW_W-1:0]     r_row;
    logic [WCNT_W-1:0]    r_w;
    logic [1:0]           r_nb;
    logic [COL_W-1:0]     r_lcol;
    logic [COL_W-1:0]     r_rcol;
    logic                 r_lhit;
    logic                 r_rhit;
    logic                 r_rd_zero;
    logic                 n_rd_zero;
    logic                 rd_en;
    logic [WCNT_W-1:0]    rd_word;
    logic                 r_m_valid;
    logic [ROW_W-1:0]     r_m_row;
    logic [COL_W-1:0]     r_m_left;
    logic [COL_W-1:0]     r_m_right;
    logic [COL_W-1:0]     r_m_mid;
    logic                 r_m_lhit;
    logic                 r_m_rhit;
    logic                 r_m_last;

    logic [ROW_W-1:0]     in_row;
    logic [WIDX_W-1:0]    in_word;
    logic [PIX_W-1:0]     in_bits;
    logic                 in_accept;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] rd_data;
    logic [WCNT_W-1:0]    ws;
    logic [WCNT_W-1:0]    lo_w;
    logic [WCNT_W-1:0]    hi_w;
    logic [COLX_W-1:0]    hit_col;
    logic [COLX_W-1:0]    mid_sum;
    logic                 out_free;
    logic                 last_row;
    t_search_req          sreq;
    t_search_res          sres;

    assign in_row    = i_s_tdata[5:0];
    assign in_word   = i_s_tdata[9:6];
    assign in_bits   = i_s_tdata[41:10];
    assign in_accept = i_s_tvalid && o_s_tready;
    assign wr_en     = in_accept && (in_row < ROW_W'(BAND_ROWS))
                       && (in_word < WIDX_W'(WORDS_PER_ROW));
    assign wr_data   = (in_word == WIDX_W'(WORDS_PER_ROW - 1)) ? (in_bits & LAST_MASK)
                                                                : in_bits;

    lcrs_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(store_addr(in_row, WCNT_W'(in_word))),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(store_addr(r_row, rd_word)),
        .o_rdata(ram_q)
    );

    assign rd_data  = r_rd_zero ? '0 : ram_q;
    assign ws       = WCNT_W'(r_begin[COL_W-1:WB_LOG]);
    assign lo_w     = sreq.lo[COLX_W-1:WB_LOG];
    assign hi_w     = sreq.hi[COLX_W-1:WB_LOG];
    assign hit_col  = {r_w, sres.pos};
    assign mid_sum  = COLX_W'(r_lcol) + COLX_W'(r_rcol);
    assign out_free = !r_m_valid || i_m_tready;
    assign last_row = (r_row == ROW_W'(BAND_ROWS - 1));

    lcrs_word_search u_search (
        .i_req (sreq),
        .i_data(rd_data),
        .o_res (sres)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && i_s_tlast) begin
                    n_state = ST_L_START;
                end
            end
            ST_L_START: begin
                n_state = (r_begin > r_left_limit) ? ST_L_PRIME : ST_R_START;
            end
            ST_L_PRIME: begin
                n_state = ST_L_EVAL;
            end
            ST_L_EVAL: begin
                if (sres.hit || (r_w <= lo_w)) begin
                    n_state = ST_R_START;
                end
            end
            ST_R_START: begin
                n_state = (r_begin < r_right_limit) ? ST_R_PRIME : ST_EMIT;
            end
            ST_R_PRIME: begin
                n_state = ST_R_EVAL;
            end
            ST_R_EVAL: begin
                if (sres.hit || (r_w >= hi_w)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = last_row ? ST_IDLE : ST_L_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        rd_en          = 1'b0;
        rd_word        = r_w;
        sreq.dir_right = 1'b0;
        sreq.word      = r_w;
        sreq.nb        = r_nb;
        sreq.lo        = COLX_W'(r_left_limit) + COLX_W'(1);
        sreq.hi        = COLX_W'(r_begin);
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_L_START: begin
                rd_en   = 1'b1;
                rd_word = ws + WCNT_W'(1);
            end
            ST_L_PRIME: begin
                rd_en = 1'b1;
            end
            ST_L_EVAL: begin
                rd_en   = 1'b1;
                rd_word = r_w - WCNT_W'(1);
            end
            ST_R_START: begin
                rd_en   = 1'b1;
                rd_word = ws - WCNT_W'(1);
            end
            ST_R_PRIME: begin
                rd_en = 1'b1;
            end
            ST_R_EVAL: begin
                rd_en          = 1'b1;
                rd_word        = r_w + WCNT_W'(1);
                sreq.dir_right = 1'b1;
                sreq.lo        = COLX_W'(r_begin);
                sreq.hi        = COLX_W'(r_right_limit) - COLX_W'(1);
            end
            ST_EMIT: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
        n_rd_zero = (rd_word >= WCNT_W'(WORDS_PER_ROW))
                    || ((r_state == ST_R_START) && (ws == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start_col   <= START_COL_RST;
            r_left_limit  <= LEFT_LIMIT_RST;
            r_right_limit <= RIGHT_LIMIT_RST;
            r_begin       <= START_COL_RST;
            r_row         <= '0;
            r_rd_zero     <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_zero <= n_rd_zero;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_COL:   r_start_col   <= i_cfg_data;
                    CFG_LEFT_LIMIT:  r_left_limit  <= i_cfg_data;
                    CFG_RIGHT_LIMIT: r_right_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_IDLE) && in_accept && i_s_tlast) begin
                r_begin <= r_start_col;
                r_row   <= '0;
            end
            if ((r_state == ST_EMIT) && out_free) begin
                r_m_valid <= 1'b1;
                r_begin   <= mid_sum[COLX_W-1:1];
                r_row     <= r_row + ROW_W'(1);
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_L_START: begin
                r_w    <= ws;
                r_lhit <= 1'b0;
                r_lcol <= r_left_limit;
            end
            ST_L_PRIME: begin
                r_nb <= {1'b0, rd_data[0]};
            end
            ST_L_EVAL: begin
                if (sres.hit) begin
                    r_lhit <= 1'b1;
                    r_lcol <= hit_col[COL_W-1:0];
                end else begin
                    r_nb <= {1'b0, rd_data[0]};
                    r_w  <= r_w - WCNT_W'(1);
                end
            end
            ST_R_START: begin
                r_w    <= ws;
                r_rhit <= 1'b0;
                r_rcol <= r_right_limit;
            end
            ST_R_PRIME: begin
                r_nb <= rd_data[WORD_BITS-1:WORD_BITS-2];
            end
            ST_R_EVAL: begin
                if (sres.hit) begin
                    r_rhit <= 1'b1;
                    r_rcol <= hit_col[COL_W-1:0];
                end else begin
                    r_nb <= rd_data[WORD_BITS-1:WORD_BITS-2];
                    r_w  <= r_w + WCNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_m_row   <= r_row;
                    r_m_left  <= r_lcol;
                    r_m_right <= r_rcol;
                    r_m_mid   <= mid_sum[COLX_W-1:1];
                    r_m_lhit  <= r_lhit;
                    r_m_rhit  <= r_rhit;
                    r_m_last  <= last_row;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'b0, r_m_mid, r_m_right, r_m_left, r_m_row};
    assign o_m_tuser  = {r_m_rhit, r_m_lhit};
    assign o_m_tlast  = r_m_last;

    a_left_word_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_L_EVAL) |-> (r_w >= lo_w))
        else $error("left search walked below its limit word");

    a_right_word_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R_EVAL) |-> (r_w <= hi_w))
        else $error("right search walked above its limit word");

    a_left_hit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_lhit)
            |-> ((r_lcol > r_left_limit) && (r_lcol <= r_begin)))
        else $error("left edge outside its search window");

    a_right_hit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_rhit)
            |-> ((r_rcol >= r_begin) && (r_rcol < r_right_limit)))
        else $error("right edge outside its search window");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && out_free && last_row)
            |=> ((r_state == ST_IDLE) && r_m_valid && r_m_last))
        else $error("scan did not end after the top row");
endmodule
